// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the path segment core.
// Every check samples on clk and is switched off while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the trigger
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pc2cs_pkg.sv -----
// ---------------------------------------------------------------------------
// pc2cs_pkg
// Types, codes and saturating arithmetic for the path command to cubic
// segment converter, including the stages of the reciprocal divide by three.
// ---------------------------------------------------------------------------
`default_nettype none

package pc2cs_pkg;

  // Coordinate format: signed fixed point
  localparam int COORD_BITS = 32;
  // Headroom for sums, doubled values and the 2/3 result
  localparam int WIDE       = COORD_BITS + 3;
  // Divide by three: m = h*2^DIV_LO + l, so m/3 = h*HI_MUL + (HI_REM*h + l)/3,
  // the last term by a small reciprocal multiply
  localparam int DIV_LO     = WIDE / 2 + 1;
  localparam int DIV_HI     = WIDE - DIV_LO;
  localparam int DIV_S      = DIV_LO + 1;
  localparam int DIV_K      = DIV_LO + 2;
  localparam int DIV_P      = 2 * DIV_S;
  localparam logic [WIDE-1:0]  HI_MUL = WIDE'((1 << DIV_LO) / 3);
  localparam logic [DIV_S-1:0] HI_REM = DIV_S'((1 << DIV_LO) % 3);
  localparam logic [DIV_P-1:0] RECIP  = DIV_P'(((1 << DIV_K) + 2) / 3);
  // Split stage, then quotient stage
  localparam int DIV_STAGES = 2;
  // Entry, operand prep, division stages, output
  localparam int PIPE_STAGES = DIV_STAGES + 3;
  // Four 2/3 results per quadratic: ctrl1 x/y, ctrl2 x/y
  localparam int LANES      = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE-1:0]       wide_t;

  // Offset that keeps the dividend positive: 3 * 2^(COORD_BITS+1)
  localparam logic [WIDE-1:0] M_OFFSET = WIDE'(3) << (COORD_BITS + 1);
  // Same offset after division
  localparam logic [WIDE-1:0] Q_BIAS   = WIDE'(1) << (COORD_BITS + 1);

  typedef enum logic [3:0] {
    OP_MOVE         = 4'd0,
    OP_LINE         = 4'd1,
    OP_HORIZ        = 4'd2,
    OP_VERT         = 4'd3,
    OP_CUBIC        = 4'd4,
    OP_SMOOTH_CUBIC = 4'd5,
    OP_QUAD         = 4'd6,
    OP_SMOOTH_QUAD  = 4'd7,
    OP_CLOSE        = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_CUBIC = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CURVE_NONE  = 2'd0,
    CURVE_CUBIC = 2'd1,
    CURVE_QUAD  = 2'd2
  } curve_t;

  // One segment as it travels down the pipe; for a quadratic the
  // ctrl1 fields carry the quad control until the output stage
  typedef struct packed {
    kind_t  kind;
    logic   quad;
    coord_t from_x;
    coord_t from_y;
    coord_t ctrl1_x;
    coord_t ctrl1_y;
    coord_t ctrl2_x;
    coord_t ctrl2_y;
    coord_t to_x;
    coord_t to_y;
  } seg_t;

  // Pipe word: segment plus the division lanes
  typedef struct packed {
    seg_t                          seg;
    logic [LANES-1:0][WIDE-1:0]    quo;
    logic [LANES-1:0][DIV_S-1:0]   part;
  } stage_t;

  function automatic wide_t widen(coord_t v);
    return {{(WIDE - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  // Clamp to the coordinate range
  function automatic coord_t sat_coord(wide_t v);
    logic [WIDE-COORD_BITS:0] top;
    top = v[WIDE-1:COORD_BITS-1];
    if ((&top) || !(|top)) begin
      return v[COORD_BITS-1:0];
    end else if (v[WIDE-1]) begin
      return {1'b1, {(COORD_BITS - 1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS - 1){1'b1}}};
    end
  endfunction

  // Given coordinate, made absolute when relative
  function automatic coord_t coord_in(coord_t raw, logic rel, coord_t base);
    return rel ? sat_coord(widen(raw) + widen(base)) : raw;
  endfunction

  // 2*cur - prev, saturated
  function automatic coord_t reflect(coord_t cur, coord_t prev);
    return sat_coord(widen(cur) + widen(cur) - widen(prev));
  endfunction

  // Load the lanes with 2*(c - p) + 1 + offset; the quotient of that by
  // three, less the bias, is round(2*(c - p)/3)
  function automatic stage_t div_prep(stage_t s);
    stage_t          o;
    coord_t          p_l [LANES];
    coord_t          c_l [LANES];
    logic [WIDE-1:0] pw;
    logic [WIDE-1:0] cw;
    o = s;
    p_l[0] = s.seg.from_x;
    p_l[1] = s.seg.from_y;
    p_l[2] = s.seg.to_x;
    p_l[3] = s.seg.to_y;
    c_l[0] = s.seg.ctrl1_x;
    c_l[1] = s.seg.ctrl1_y;
    c_l[2] = s.seg.ctrl1_x;
    c_l[3] = s.seg.ctrl1_y;
    for (int l = 0; l < LANES; l++) begin
      pw = {{(WIDE - COORD_BITS){p_l[l][COORD_BITS-1]}}, p_l[l]};
      cw = {{(WIDE - COORD_BITS){c_l[l][COORD_BITS-1]}}, c_l[l]};
      o.quo[l]  = ((cw - pw) << 1) + WIDE'(1) + M_OFFSET;
      o.part[l] = '0;
    end
    return o;
  endfunction

  // Split the dividend: high part times 2^DIV_LO/3, and the small
  // leftover sum that still needs dividing
  function automatic stage_t div_split(stage_t s);
    stage_t            o;
    logic [DIV_HI-1:0] hi;
    logic [DIV_LO-1:0] lo;
    o = s;
    for (int l = 0; l < LANES; l++) begin
      hi        = s.quo[l][WIDE-1:DIV_LO];
      lo        = s.quo[l][DIV_LO-1:0];
      o.quo[l]  = WIDE'(hi) * HI_MUL;
      o.part[l] = HI_REM * DIV_S'(hi) + DIV_S'(lo);
    end
    return o;
  endfunction

  // Leftover divided by three through its reciprocal, added to the quotient
  function automatic stage_t div_quot(stage_t s);
    stage_t           o;
    logic [DIV_P-1:0] prod;
    o = s;
    for (int l = 0; l < LANES; l++) begin
      prod     = DIV_P'(s.part[l]) * RECIP;
      o.quo[l] = s.quo[l] + WIDE'(prod[DIV_P-1:DIV_K]);
    end
    return o;
  endfunction

  // Add the 2/3 offsets to their base points for quadratics
  function automatic stage_t div_finish(stage_t s);
    stage_t o;
    wide_t  q_l [LANES];
    o = s;
    for (int l = 0; l < LANES; l++) begin
      q_l[l] = s.quo[l] - Q_BIAS;
    end
    if (s.seg.quad) begin
      o.seg.ctrl1_x = sat_coord(widen(s.seg.from_x) + q_l[0]);
      o.seg.ctrl1_y = sat_coord(widen(s.seg.from_y) + q_l[1]);
      o.seg.ctrl2_x = sat_coord(widen(s.seg.to_x) + q_l[2]);
      o.seg.ctrl2_y = sat_coord(widen(s.seg.to_y) + q_l[3]);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/path_command_to_cubic_segments_top.sv -----
// ---------------------------------------------------------------------------
// path_command_to_cubic_segments_top
// Turns parsed path commands into absolute segments (figure start, line,
// cubic, close), tracking current point, figure start and last control.
//
//   channel | flow | handshake            | word
//   cmd     | in   | cmd_valid/cmd_stall  | opcode, relative, p1..p3 x/y
//   seg     | out  | seg_valid/seg_stall  | seg_kind, from, ctrl1, ctrl2, to
//
// One command per cycle while cmd_stall is low; a segment passes the entry,
// prep, split, quotient and finish registers. The rate is set by the entry
// stage, whose state update is one saturating add per coordinate. The
// quadratic 2/3 rule runs in the prep, split, reciprocal quotient and
// finish stages. Reset is synchronous: it empties the pipe and zeroes the
// path state. seg_stall backs up through the stages; cmd_stall rises only
// when every stage holds a word. Unknown opcodes are taken, give no segment.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module path_command_to_cubic_segments_top
  import pc2cs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // command channel
  input  wire logic         cmd_valid,
  output logic              cmd_stall,
  input  wire logic [3:0]   opcode,
  input  wire logic         relative,
  input  wire coord_t       p1_x,
  input  wire coord_t       p1_y,
  input  wire coord_t       p2_x,
  input  wire coord_t       p2_y,
  input  wire coord_t       p3_x,
  input  wire coord_t       p3_y,
  // segment channel
  output logic              seg_valid,
  input  wire logic         seg_stall,
  output logic [1:0]        seg_kind,
  output coord_t            from_x,
  output coord_t            from_y,
  output coord_t            ctrl1_x,
  output coord_t            ctrl1_y,
  output coord_t            ctrl2_x,
  output coord_t            ctrl2_y,
  output coord_t            to_x,
  output coord_t            to_y
);

  localparam int LAST = PIPE_STAGES - 1;

  // Path state
  coord_t cur_x, cur_y;
  coord_t fig_x, fig_y;
  coord_t last_ctrl_x, last_ctrl_y;
  curve_t last_curve;

  coord_t fig_x_next, fig_y_next;
  coord_t last_ctrl_x_next, last_ctrl_y_next;
  curve_t last_curve_next;

  // Pipe
  stage_t                 pipe [PIPE_STAGES];
  stage_t                 nxt  [PIPE_STAGES];
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] rdy;

  op_t    op;
  stage_t entry;
  logic   entry_ok;
  logic   accept;
  coord_t q_x, q_y;

  // Check terms
  logic                    seg_ctrl_ok;
  logic                    bad_op_taken;
  logic                    close_taken;
  logic                    at_fig;
  logic [2*COORD_BITS+1:0] path_pos;

  assign op     = op_t'(opcode);
  assign accept = cmd_valid && !cmd_stall;

  // Entry decode: absolute points and next path state
  always_comb begin
    entry             = '0;
    entry.seg.from_x  = cur_x;
    entry.seg.from_y  = cur_y;
    entry.seg.to_x    = cur_x;
    entry.seg.to_y    = cur_y;
    entry_ok          = 1'b1;
    fig_x_next        = fig_x;
    fig_y_next        = fig_y;
    last_ctrl_x_next  = last_ctrl_x;
    last_ctrl_y_next  = last_ctrl_y;
    last_curve_next   = CURVE_NONE;
    q_x               = cur_x;
    q_y               = cur_y;
    unique case (op)
      OP_MOVE: begin
        entry.seg.kind = KIND_START;
        entry.seg.to_x = coord_in(p1_x, relative, cur_x);
        entry.seg.to_y = coord_in(p1_y, relative, cur_y);
        fig_x_next     = entry.seg.to_x;
        fig_y_next     = entry.seg.to_y;
      end
      OP_LINE: begin
        entry.seg.kind = KIND_LINE;
        entry.seg.to_x = coord_in(p1_x, relative, cur_x);
        entry.seg.to_y = coord_in(p1_y, relative, cur_y);
      end
      OP_HORIZ: begin
        entry.seg.kind = KIND_LINE;
        entry.seg.to_x = coord_in(p1_x, relative, cur_x);
      end
      OP_VERT: begin
        entry.seg.kind = KIND_LINE;
        entry.seg.to_y = coord_in(p1_y, relative, cur_y);
      end
      OP_CUBIC, OP_SMOOTH_CUBIC: begin
        entry.seg.kind = KIND_CUBIC;
        if (op == OP_CUBIC) begin
          entry.seg.ctrl1_x = coord_in(p1_x, relative, cur_x);
          entry.seg.ctrl1_y = coord_in(p1_y, relative, cur_y);
        end else if (last_curve == CURVE_CUBIC) begin
          entry.seg.ctrl1_x = reflect(cur_x, last_ctrl_x);
          entry.seg.ctrl1_y = reflect(cur_y, last_ctrl_y);
        end else begin
          entry.seg.ctrl1_x = cur_x;
          entry.seg.ctrl1_y = cur_y;
        end
        entry.seg.ctrl2_x = coord_in(p2_x, relative, cur_x);
        entry.seg.ctrl2_y = coord_in(p2_y, relative, cur_y);
        entry.seg.to_x    = coord_in(p3_x, relative, cur_x);
        entry.seg.to_y    = coord_in(p3_y, relative, cur_y);
        last_ctrl_x_next  = entry.seg.ctrl2_x;
        last_ctrl_y_next  = entry.seg.ctrl2_y;
        last_curve_next   = CURVE_CUBIC;
      end
      OP_QUAD, OP_SMOOTH_QUAD: begin
        entry.seg.kind = KIND_CUBIC;
        entry.seg.quad = 1'b1;
        if (op == OP_QUAD) begin
          q_x = coord_in(p1_x, relative, cur_x);
          q_y = coord_in(p1_y, relative, cur_y);
        end else if (last_curve == CURVE_QUAD) begin
          q_x = reflect(cur_x, last_ctrl_x);
          q_y = reflect(cur_y, last_ctrl_y);
        end
        // quad control rides in ctrl1 until the 2/3 rule is applied
        entry.seg.ctrl1_x = q_x;
        entry.seg.ctrl1_y = q_y;
        entry.seg.to_x    = coord_in(p3_x, relative, cur_x);
        entry.seg.to_y    = coord_in(p3_y, relative, cur_y);
        last_ctrl_x_next  = q_x;
        last_ctrl_y_next  = q_y;
        last_curve_next   = CURVE_QUAD;
      end
      OP_CLOSE: begin
        entry.seg.kind = KIND_CLOSE;
        entry.seg.to_x = fig_x;
        entry.seg.to_y = fig_y;
      end
      default: begin
        entry_ok        = 1'b0;
        last_curve_next = last_curve;
      end
    endcase
  end

  // Path state update on every taken command that has a meaning
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      fig_x       <= '0;
      fig_y       <= '0;
      last_ctrl_x <= '0;
      last_ctrl_y <= '0;
      last_curve  <= CURVE_NONE;
    end else if (accept && entry_ok) begin
      cur_x       <= entry.seg.to_x;
      cur_y       <= entry.seg.to_y;
      fig_x       <= fig_x_next;
      fig_y       <= fig_y_next;
      last_ctrl_x <= last_ctrl_x_next;
      last_ctrl_y <= last_ctrl_y_next;
      last_curve  <= last_curve_next;
    end
  end

  // Stage functions: prep, split, quotient, finish
  assign nxt[0]    = entry;
  assign nxt[1]    = div_prep(pipe[0]);
  assign nxt[2]    = div_split(pipe[1]);
  assign nxt[3]    = div_quot(pipe[2]);
  assign nxt[LAST] = div_finish(pipe[LAST-1]);

  // A stage moves on when it is empty or the one after it moves
  always_comb begin
    rdy[LAST] = !vld[LAST] || !seg_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign cmd_stall = !rdy[0];

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= cmd_valid && entry_ok;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage words
  always_ff @(posedge clk) begin
    for (int i = 0; i < PIPE_STAGES; i++) begin
      if (rdy[i]) pipe[i] <= nxt[i];
    end
  end

  // Outputs straight from the last stage
  assign seg_valid = vld[LAST];
  assign seg_kind  = pipe[LAST].seg.kind;
  assign from_x    = pipe[LAST].seg.from_x;
  assign from_y    = pipe[LAST].seg.from_y;
  assign ctrl1_x   = pipe[LAST].seg.ctrl1_x;
  assign ctrl1_y   = pipe[LAST].seg.ctrl1_y;
  assign ctrl2_x   = pipe[LAST].seg.ctrl2_x;
  assign ctrl2_y   = pipe[LAST].seg.ctrl2_y;
  assign to_x      = pipe[LAST].seg.to_x;
  assign to_y      = pipe[LAST].seg.to_y;

  // Terms for the checks
  assign seg_ctrl_ok  = !seg_valid || (seg_kind == KIND_CUBIC) ||
                        ((ctrl1_x == '0) && (ctrl1_y == '0) &&
                         (ctrl2_x == '0) && (ctrl2_y == '0));
  assign bad_op_taken = accept && !entry_ok;
  assign close_taken  = accept && (op == OP_CLOSE);
  assign at_fig       = (cur_x == fig_x) && (cur_y == fig_y);
  assign path_pos     = {cur_x, cur_y, last_curve};

  // Checks
  `CHK_ALWAYS(a_ctrl_zero, seg_ctrl_ok, "control point set on a non-cubic segment")
  `CHK_NEXT(a_bad_op_hold, bad_op_taken, $stable(path_pos), "unknown opcode changed path state")
  `CHK_NEXT(a_close_home, close_taken, at_fig, "close did not return to the figure start")
  `CHK_ALWAYS(a_stall_full, !cmd_stall || (&vld), "command stalled with a free stage")

endmodule

`default_nettype wire

// ----- sim/path_command_to_cubic_segments_top_tb.sv -----
// ---------------------------------------------------------------------------
// path_command_to_cubic_segments_top_tb
// Drives parsed path commands into the segment converter and checks every
// segment word against an in-bench path tracker (current point, figure
// start, last control, curve kind, 2/3 rule, saturation). A directed set of
// edge cases is followed by random path-like sequences, with bursty sending
// and a patterned stall on the segment side.
// ---------------------------------------------------------------------------
`default_nettype none

module path_command_to_cubic_segments_top_tb
  import pc2cs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CMD_COUNT   = 1750;
  localparam int     CYCLE_LIMIT = 400000;
  localparam coord_t COORD_MAX   = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam coord_t COORD_MIN   = {1'b1, {(COORD_BITS - 1){1'b0}}};

  typedef struct {
    kind_t  kind;
    coord_t from_x;
    coord_t from_y;
    coord_t ctrl1_x;
    coord_t ctrl1_y;
    coord_t ctrl2_x;
    coord_t ctrl2_y;
    coord_t to_x;
    coord_t to_y;
  } seg_word_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // Path tracker and store of segments still to arrive
  class segment_scoreboard;
    coord_t    cur_x, cur_y, fig_x, fig_y, ctl_x, ctl_y;
    curve_t    prev_curve;
    seg_word_t pending_segs[$];
    int        errors;

    function new();
      cur_x = '0; cur_y = '0; fig_x = '0; fig_y = '0;
      ctl_x = '0; ctl_y = '0;
      prev_curve = CURVE_NONE;
      errors = 0;
    endfunction

    function int outstanding();
      return pending_segs.size();
    endfunction

    function coord_t clamp(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return COORD_MAX;
      if (v < lo) return COORD_MIN;
      return coord_t'(v);
    endfunction

    function coord_t absolute(coord_t raw, logic rel, coord_t base);
      return rel ? clamp(longint'(raw) + longint'(base)) : raw;
    endfunction

    function coord_t mirror(coord_t c, coord_t prev);
      return clamp(2 * longint'(c) - longint'(prev));
    endfunction

    // p + round(2*(c-p)/3), floor division then round half up
    function coord_t two_thirds_point(coord_t p, coord_t c);
      longint n;
      longint q;
      longint r;
      n = 2 * (longint'(c) - longint'(p));
      q = n / 3;
      r = n % 3;
      if (r < 0) begin
        q = q - 1;
        r = r + 3;
      end
      if (r == 2) q = q + 1;
      return clamp(longint'(p) + q);
    endfunction

    // Advance the path state by one command and queue its segment
    function void note_command(logic [3:0] op, logic rel, coord_t p1x, coord_t p1y,
                               coord_t p2x, coord_t p2y, coord_t p3x, coord_t p3y);
      seg_word_t s;
      coord_t    qx, qy;
      s.kind = KIND_LINE;
      s.from_x = cur_x; s.from_y = cur_y;
      s.ctrl1_x = '0; s.ctrl1_y = '0; s.ctrl2_x = '0; s.ctrl2_y = '0;
      case (op)
        OP_MOVE: begin
          s.kind = KIND_START;
          s.to_x = absolute(p1x, rel, cur_x);
          s.to_y = absolute(p1y, rel, cur_y);
          fig_x = s.to_x; fig_y = s.to_y;
          prev_curve = CURVE_NONE;
        end
        OP_LINE: begin
          s.to_x = absolute(p1x, rel, cur_x);
          s.to_y = absolute(p1y, rel, cur_y);
          prev_curve = CURVE_NONE;
        end
        OP_HORIZ: begin
          s.to_x = absolute(p1x, rel, cur_x);
          s.to_y = cur_y;
          prev_curve = CURVE_NONE;
        end
        OP_VERT: begin
          s.to_x = cur_x;
          s.to_y = absolute(p1y, rel, cur_y);
          prev_curve = CURVE_NONE;
        end
        OP_CUBIC, OP_SMOOTH_CUBIC: begin
          s.kind = KIND_CUBIC;
          if (op == OP_CUBIC) begin
            s.ctrl1_x = absolute(p1x, rel, cur_x);
            s.ctrl1_y = absolute(p1y, rel, cur_y);
          end else if (prev_curve == CURVE_CUBIC) begin
            s.ctrl1_x = mirror(cur_x, ctl_x);
            s.ctrl1_y = mirror(cur_y, ctl_y);
          end else begin
            s.ctrl1_x = cur_x;
            s.ctrl1_y = cur_y;
          end
          s.ctrl2_x = absolute(p2x, rel, cur_x);
          s.ctrl2_y = absolute(p2y, rel, cur_y);
          s.to_x = absolute(p3x, rel, cur_x);
          s.to_y = absolute(p3y, rel, cur_y);
          ctl_x = s.ctrl2_x; ctl_y = s.ctrl2_y;
          prev_curve = CURVE_CUBIC;
        end
        OP_QUAD, OP_SMOOTH_QUAD: begin
          s.kind = KIND_CUBIC;
          if (op == OP_QUAD) begin
            qx = absolute(p1x, rel, cur_x);
            qy = absolute(p1y, rel, cur_y);
          end else if (prev_curve == CURVE_QUAD) begin
            qx = mirror(cur_x, ctl_x);
            qy = mirror(cur_y, ctl_y);
          end else begin
            qx = cur_x;
            qy = cur_y;
          end
          s.to_x = absolute(p3x, rel, cur_x);
          s.to_y = absolute(p3y, rel, cur_y);
          s.ctrl1_x = two_thirds_point(cur_x, qx);
          s.ctrl1_y = two_thirds_point(cur_y, qy);
          s.ctrl2_x = two_thirds_point(s.to_x, qx);
          s.ctrl2_y = two_thirds_point(s.to_y, qy);
          ctl_x = qx; ctl_y = qy;
          prev_curve = CURVE_QUAD;
        end
        OP_CLOSE: begin
          s.kind = KIND_CLOSE;
          s.to_x = fig_x; s.to_y = fig_y;
          prev_curve = CURVE_NONE;
        end
        default: return;  // unknown opcode: no segment, state kept
      endcase
      cur_x = s.to_x; cur_y = s.to_y;
      pending_segs.push_back(s);
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare an arrived segment with the oldest one waiting
    function void check_segment(seg_word_t got);
      seg_word_t want;
      if (pending_segs.size() == 0) begin
        errors++;
        $display("%0t: segment with none waiting: expected nothing, actual kind %0d to (%0d,%0d)",
                 $time, got.kind, got.to_x, got.to_y);
        return;
      end
      want = pending_segs.pop_front();
      compare_field("seg_kind", want.kind, got.kind);
      compare_field("from_x", want.from_x, got.from_x);
      compare_field("from_y", want.from_y, got.from_y);
      compare_field("ctrl1_x", want.ctrl1_x, got.ctrl1_x);
      compare_field("ctrl1_y", want.ctrl1_y, got.ctrl1_y);
      compare_field("ctrl2_x", want.ctrl2_x, got.ctrl2_x);
      compare_field("ctrl2_y", want.ctrl2_y, got.ctrl2_y);
      compare_field("to_x", want.to_x, got.to_x);
      compare_field("to_y", want.to_y, got.to_y);
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [3:0]  opcode    = '0;
  logic        relative  = 1'b0;
  coord_t      p1_x      = '0;
  coord_t      p1_y      = '0;
  coord_t      p2_x      = '0;
  coord_t      p2_y      = '0;
  coord_t      p3_x      = '0;
  coord_t      p3_y      = '0;
  logic        seg_valid;
  logic        seg_stall = 1'b0;
  logic [1:0]  seg_kind;
  coord_t      from_x, from_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, to_x, to_y;

  segment_scoreboard sb;
  int unsigned       cycle_count = 0;
  stall_mode_t       stall_mode  = STALL_NONE;
  int unsigned       stall_left  = 0;
  int unsigned       stall_phase = 0;
  logic [3:0]        prev_op     = OP_MOVE;

  path_command_to_cubic_segments_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .opcode    (opcode),
    .relative  (relative),
    .p1_x      (p1_x),
    .p1_y      (p1_y),
    .p2_x      (p2_x),
    .p2_y      (p2_y),
    .p3_x      (p3_x),
    .p3_y      (p3_y),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg_kind  (seg_kind),
    .from_x    (from_x),
    .from_y    (from_y),
    .ctrl1_x   (ctrl1_x),
    .ctrl1_y   (ctrl1_y),
    .ctrl2_x   (ctrl2_x),
    .ctrl2_y   (ctrl2_y),
    .to_x      (to_x),
    .to_y      (to_y)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL path_command_to_cubic_segments_top");
      $finish;
    end
  end

  // Track commands as they are taken
  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall)
      sb.note_command(opcode, relative, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y);
  end

  // Check segments as they leave
  always @(posedge clk) begin
    seg_word_t got;
    if (!rst && seg_valid && !seg_stall) begin
      got.kind = kind_t'(seg_kind);
      got.from_x = from_x;   got.from_y = from_y;
      got.ctrl1_x = ctrl1_x; got.ctrl1_y = ctrl1_y;
      got.ctrl2_x = ctrl2_x; got.ctrl2_y = ctrl2_y;
      got.to_x = to_x;       got.to_y = to_y;
      sb.check_segment(got);
    end
  end

  // Segment-side stall: stretches of different patterns, including none
  always @(negedge clk) begin
    if (rst) begin
      seg_stall = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(40, 300);
      end
      stall_left  = stall_left - 1;
      stall_phase = stall_phase + 1;
      case (stall_mode)
        STALL_NONE:  seg_stall = 1'b0;
        STALL_LIGHT: seg_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY: seg_stall = ($urandom_range(0, 3) != 0);
        default:     seg_stall = ((stall_phase % 7) < 3);
      endcase
    end
  end

  // Present one command word and hold it until taken
  task automatic send_command(logic [3:0] op, logic rel, coord_t a_x, coord_t a_y,
                              coord_t b_x, coord_t b_y, coord_t c_x, coord_t c_y);
    cmd_valid = 1'b1;
    opcode = op; relative = rel;
    p1_x = a_x; p1_y = a_y;
    p2_x = b_x; p2_y = b_y;
    p3_x = c_x; p3_y = c_y;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic hold_off(int unsigned n);
    cmd_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Stop sending until every queued segment is back
  task automatic drain_segments();
    cmd_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Mostly short local moves, some full-range values and extremes
  function automatic coord_t pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0:       return COORD_MAX;
        1:       return COORD_MIN;
        2:       return '0;
        3:       return '1;
        default: return coord_t'(1);
      endcase
    end else if (sel <= 3) begin
      return coord_t'($urandom());
    end
    return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  // Path-like opcode choice; smooth commands favoured after their own kind
  function automatic logic [3:0] pick_opcode(logic [3:0] last);
    int unsigned w;
    if ((last == OP_CUBIC || last == OP_SMOOTH_CUBIC) && $urandom_range(0, 1))
      return OP_SMOOTH_CUBIC;
    if ((last == OP_QUAD || last == OP_SMOOTH_QUAD) && $urandom_range(0, 1))
      return OP_SMOOTH_QUAD;
    w = $urandom_range(0, 99);
    if (w < 8)  return OP_MOVE;
    if (w < 20) return OP_LINE;
    if (w < 28) return OP_HORIZ;
    if (w < 36) return OP_VERT;
    if (w < 50) return OP_CUBIC;
    if (w < 60) return OP_SMOOTH_CUBIC;
    if (w < 74) return OP_QUAD;
    if (w < 84) return OP_SMOOTH_QUAD;
    if (w < 95) return OP_CLOSE;
    return 4'($urandom_range(9, 15));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst_left;
    logic [3:0]  op;
    sb = new();
    sent = 0;
    burst_left = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every opcode, smooth reflection rules, odd cases
    send_command(OP_MOVE, 1'b0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, '1, '1);
    send_command(OP_LINE, 1'b1, COORD_MAX, COORD_MAX, '0, '0, '0, '0);
    send_command(OP_HORIZ, 1'b1, COORD_MIN, COORD_MAX, '0, '0, '0, '0);
    send_command(OP_VERT, 1'b1, COORD_MAX, COORD_MIN, '0, '0, '0, '0);
    send_command(OP_CUBIC, 1'b0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, '0, '1);
    send_command(OP_SMOOTH_CUBIC, 1'b0, '1, '1, 32'sd1000, -32'sd1000, 32'sd65536, 32'sd3);
    send_command(OP_SMOOTH_CUBIC, 1'b1, COORD_MAX, COORD_MIN, 32'sd7, 32'sd9, -32'sd5, '1);
    send_command(OP_QUAD, 1'b0, COORD_MAX, COORD_MIN, '0, '0, COORD_MIN, COORD_MAX);
    send_command(OP_SMOOTH_QUAD, 1'b0, '0, '0, '0, '0, 32'sd1, -32'sd2);
    send_command(OP_SMOOTH_QUAD, 1'b1, '1, '1, '1, '1, 32'sd10, 32'sd11);
    send_command(OP_SMOOTH_CUBIC, 1'b0, '0, '0, 32'sd4, 32'sd5, 32'sd100, 32'sd200);
    send_command(OP_SMOOTH_QUAD, 1'b0, '0, '0, '0, '0, -32'sd100, 32'sd33);
    send_command(OP_CLOSE, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1, '1);
    send_command(4'd9, 1'b1, '1, '1, '1, '1, '1, '1);
    send_command(4'd15, 1'b0, COORD_MIN, '0, '0, '0, '0, '0);
    send_command(OP_MOVE, 1'b1, 32'sd5, -32'sd7, '1, '1, '1, '1);
    send_command(OP_QUAD, 1'b1, 32'sd1, 32'sd2, COORD_MAX, COORD_MIN, -32'sd1, 32'sd4);
    send_command(OP_SMOOTH_QUAD, 1'b0, '0, '0, '0, '0, COORD_MAX, COORD_MIN);
    send_command(OP_CLOSE, 1'b0, '0, '0, '0, '0, '0, '0);
    send_command(OP_SMOOTH_QUAD, 1'b0, '0, '0, '0, '0, 32'sd6, 32'sd9);
    send_command(OP_LINE, 1'b0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, '1, '1);
    send_command(OP_LINE, 1'b1, COORD_MIN, COORD_MIN, '0, '0, '0, '0);
    send_command(OP_CLOSE, 1'b0, '1, '1, '1, '1, '1, '1);

    // Random path traffic in bursts
    while (sent < CMD_COUNT) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 30);
      end
      if (sent == 600 || sent == 1200) drain_segments();
      op = pick_opcode(prev_op);
      send_command(op, 1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord(), pick_coord(), pick_coord());
      if (op <= OP_CLOSE) begin
        prev_op = op;
        sent = sent + 1;
      end
      burst_left = burst_left - 1;
    end

    drain_segments();
    repeat (3 * PIPE_STAGES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("PASS path_command_to_cubic_segments_top");
    end else begin
      $display("FAIL path_command_to_cubic_segments_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
